@@ hw/rtl/nls_pkg.sv @@
// Shared types, character codes and class helpers for the numeric literal scanner.
package nls_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CHAR_W          = 21;
  localparam int LEN_OUT_W       = 16;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_ZERO       = 4'd1,
    PH_INT        = 4'd2,
    PH_DOT        = 4'd3,
    PH_FRAC       = 4'd4,
    PH_EXP_SIGN   = 4'd5,
    PH_EXP_NEED   = 4'd6,
    PH_EXP_DIGITS = 4'd7,
    PH_HEX        = 4'd8,
    PH_BIN        = 4'd9,
    PH_OCT        = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DEC = 2'd0,
    KIND_HEX = 2'd1,
    KIND_BIN = 2'd2,
    KIND_OCT = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t phase;
    kind_t  kind;
    logic   digit_seen;
  } scan_state_t;

  typedef struct packed {
    kind_t      kind;
    logic       status;
    logic [1:0] reread;
  } scan_result_t;

  localparam logic [1:0] INC_NONE = 2'd0;
  localparam logic [1:0] INC_ONE  = 2'd1;
  localparam logic [1:0] INC_TWO  = 2'd2;

  localparam logic [1:0] REREAD_NONE = 2'd0;
  localparam logic [1:0] REREAD_ONE  = 2'd1;
  localparam logic [1:0] REREAD_TWO  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam char_t CH_0     = char_t'(8'h30);
  localparam char_t CH_1     = char_t'(8'h31);
  localparam char_t CH_7     = char_t'(8'h37);
  localparam char_t CH_9     = char_t'(8'h39);
  localparam char_t CH_LO_A  = char_t'(8'h61);
  localparam char_t CH_LO_F  = char_t'(8'h66);
  localparam char_t CH_LO_Z  = char_t'(8'h7a);
  localparam char_t CH_UP_A  = char_t'(8'h41);
  localparam char_t CH_UP_F  = char_t'(8'h46);
  localparam char_t CH_UP_Z  = char_t'(8'h5a);
  localparam char_t CH_LO_X  = char_t'(8'h78);
  localparam char_t CH_UP_X  = char_t'(8'h58);
  localparam char_t CH_LO_B  = char_t'(8'h62);
  localparam char_t CH_UP_B  = char_t'(8'h42);
  localparam char_t CH_LO_O  = char_t'(8'h6f);
  localparam char_t CH_UP_O  = char_t'(8'h4f);
  localparam char_t CH_DOT   = char_t'(8'h2e);
  localparam char_t CH_LO_E  = char_t'(8'h65);
  localparam char_t CH_UP_E  = char_t'(8'h45);
  localparam char_t CH_LO_D  = char_t'(8'h64);
  localparam char_t CH_UP_L  = char_t'(8'h4c);
  localparam char_t CH_PLUS  = char_t'(8'h2b);
  localparam char_t CH_MINUS = char_t'(8'h2d);

  function automatic logic is_dec(char_t c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex(char_t c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic is_alpha(char_t c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_exp(char_t c);
    return (c == CH_LO_E) || (c == CH_UP_E);
  endfunction

endpackage

@@ hw/rtl/nls_char_if.sv @@
// Character stream channel: valid/ready with code point and end marker.
interface nls_char_if;
  import nls_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  at_end;

  modport source (output valid, output char_code, output at_end, input ready);
  modport sink   (input valid, input char_code, input at_end, output ready);
endinterface

@@ hw/rtl/nls_lit_if.sv @@
// Literal result channel: valid/ready with kind, status, length and reread count.
interface nls_lit_if;
  import nls_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic                 status;
  logic [LEN_OUT_W-1:0] length;
  logic [1:0]           reread_count;

  modport source (output valid, output kind, output status, output length,
                  output reread_count, input ready);
  modport sink   (input valid, input kind, input status, input length,
                  input reread_count, output ready);
endinterface

@@ hw/rtl/nls_step.sv @@
// One scanner step: next state, saturating count and optional result for one character.
module nls_step #(
  parameter int LENGTH_BITS = nls_pkg::LENGTH_BITS_DEF
) (
  input  nls_pkg::scan_state_t  state,
  input  logic [LENGTH_BITS-1:0] count,
  input  nls_pkg::char_t        char_code,
  input  logic                  at_end,
  output nls_pkg::scan_state_t  state_next,
  output logic [LENGTH_BITS-1:0] count_next,
  output logic [LENGTH_BITS-1:0] count_sat,
  output logic                  emit,
  output nls_pkg::scan_result_t result
);
  import nls_pkg::*;

  logic                   ds;
  kind_t                  k;
  logic [LENGTH_BITS-1:0] cnt_base;
  logic [1:0]             inc;
  logic                   dint;
  logic                   fin;
  logic                   ch;
  logic [LENGTH_BITS:0]   sum;

  assign ch = !at_end;

  always_comb begin
    ds         = state.digit_seen;
    k          = state.kind;
    cnt_base   = count;
    state_next = state;
    inc        = INC_NONE;
    emit       = 1'b0;
    result     = '{kind: KIND_DEC, status: STATUS_OK, reread: REREAD_NONE};
    dint       = 1'b0;
    fin        = 1'b0;

    case (state.phase)
      PH_ZERO: begin
        if (ch && (char_code == CH_LO_X || char_code == CH_UP_X)) begin
          inc = INC_ONE;
          state_next = '{phase: PH_HEX, kind: KIND_HEX, digit_seen: 1'b0};
        end else if (ch && (char_code == CH_LO_B || char_code == CH_UP_B)) begin
          inc = INC_ONE;
          state_next = '{phase: PH_BIN, kind: KIND_BIN, digit_seen: 1'b0};
        end else if (ch && (char_code == CH_LO_O || char_code == CH_UP_O)) begin
          inc = INC_ONE;
          state_next = '{phase: PH_OCT, kind: KIND_OCT, digit_seen: 1'b0};
        end else begin
          dint = 1'b1;
        end
      end
      PH_INT: begin
        dint = 1'b1;
      end
      PH_DOT: begin
        if (ch && is_dec(char_code)) begin
          inc = INC_TWO;
          state_next.digit_seen = 1'b1;
          state_next.phase = PH_FRAC;
        end else begin
          emit = 1'b1;
          result.status = !ds;
          result.reread = at_end ? REREAD_ONE : REREAD_TWO;
        end
      end
      PH_FRAC: begin
        if (ch && is_dec(char_code)) begin
          inc = INC_ONE;
        end else if (ch && is_exp(char_code)) begin
          inc = INC_ONE;
          state_next.phase = PH_EXP_SIGN;
        end else begin
          fin = 1'b1;
        end
      end
      PH_EXP_SIGN: begin
        if (ch && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
          inc = INC_ONE;
          state_next.phase = PH_EXP_NEED;
        end else if (ch && is_dec(char_code)) begin
          inc = INC_ONE;
          state_next.phase = PH_EXP_DIGITS;
        end else begin
          emit = 1'b1;
          result.status = STATUS_BAD;
          result.reread = at_end ? REREAD_NONE : REREAD_ONE;
        end
      end
      PH_EXP_NEED: begin
        if (ch && is_dec(char_code)) begin
          inc = INC_ONE;
          state_next.phase = PH_EXP_DIGITS;
        end else begin
          emit = 1'b1;
          result.status = STATUS_BAD;
          result.reread = at_end ? REREAD_NONE : REREAD_ONE;
        end
      end
      PH_EXP_DIGITS: begin
        if (ch && is_dec(char_code)) begin
          inc = INC_ONE;
        end else begin
          fin = 1'b1;
        end
      end
      PH_HEX: begin
        if (ch && is_hex(char_code)) begin
          inc = INC_ONE;
          state_next.digit_seen = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      PH_BIN: begin
        if (ch && (char_code == CH_0 || char_code == CH_1)) begin
          inc = INC_ONE;
          state_next.digit_seen = 1'b1;
        end else if (ch && is_dec(char_code)) begin
          emit = 1'b1;
          result.status = STATUS_BAD;
          result.reread = REREAD_ONE;
        end else begin
          fin = 1'b1;
        end
      end
      PH_OCT: begin
        if (ch && (char_code >= CH_0) && (char_code <= CH_7)) begin
          inc = INC_ONE;
          state_next.digit_seen = 1'b1;
        end else if (ch && is_dec(char_code)) begin
          emit = 1'b1;
          result.status = STATUS_BAD;
          result.reread = REREAD_ONE;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        // start of a literal: state is cleared before the character is used
        ds = 1'b0;
        k = KIND_DEC;
        cnt_base = '0;
        state_next = '{phase: PH_START, kind: KIND_DEC, digit_seen: 1'b0};
        if (ch && char_code == CH_0) begin
          inc = INC_ONE;
          state_next.digit_seen = 1'b1;
          state_next.phase = PH_ZERO;
        end else begin
          dint = 1'b1;
        end
      end
    endcase

    if (dint) begin
      if (ch && is_dec(char_code)) begin
        inc = INC_ONE;
        state_next.digit_seen = 1'b1;
        state_next.phase = PH_INT;
      end else if (ch && char_code == CH_DOT) begin
        state_next.phase = PH_DOT;
      end else if (ch && is_exp(char_code) && ds) begin
        inc = INC_ONE;
        state_next.phase = PH_EXP_SIGN;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      emit = 1'b1;
      if (at_end) begin
        result.status = !ds;
        result.reread = REREAD_NONE;
      end else if (!ds) begin
        result.status = STATUS_BAD;
        result.reread = REREAD_ONE;
      end else if (is_alpha(char_code)) begin
        if (char_code == CH_LO_F || char_code == CH_LO_D || char_code == CH_UP_L) begin
          inc = INC_ONE;
          result.status = STATUS_OK;
          result.reread = REREAD_NONE;
        end else begin
          result.status = STATUS_BAD;
          result.reread = REREAD_ONE;
        end
      end else begin
        result.status = STATUS_OK;
        result.reread = REREAD_ONE;
      end
    end

    result.kind = k;
    if (emit) begin
      state_next = '{phase: PH_START, kind: KIND_DEC, digit_seen: 1'b0};
    end
  end

  assign sum        = {1'b0, cnt_base} + (LENGTH_BITS+1)'(inc);
  assign count_sat  = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
  assign count_next = emit ? '0 : count_sat;

endmodule

@@ hw/rtl/numeric_literal_scanner.sv @@
// Top level of the numeric literal scanner: state registers and result register.
//
//   channel   role   payload
//   text      sink   char_code[20:0], at_end
//   token     source kind[1:0], status, length[15:0], reread_count[1:0]
//
// One character per cycle while text.ready is high; a result appears in the cycle after
// the transaction that decides the literal, held in the result register.
// Synchronous reset returns the scanner to its start state and drops any result.
// text.ready falls only while a result is held and token.ready is low.
module numeric_literal_scanner #(
  parameter int LENGTH_BITS = nls_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  nls_char_if.sink      text,
  nls_lit_if.source     token
);
  import nls_pkg::*;

  scan_state_t            state;
  scan_state_t            state_next;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_next;
  logic [LENGTH_BITS-1:0] count_sat;
  logic                   emit;
  scan_result_t           result;
  logic                   accept;
  logic [31:0]            len_wide;

  nls_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .state      (state),
    .count      (count),
    .char_code  (text.char_code),
    .at_end     (text.at_end),
    .state_next (state_next),
    .count_next (count_next),
    .count_sat  (count_sat),
    .emit       (emit),
    .result     (result)
  );

  assign text.ready = !token.valid || token.ready;
  assign accept     = text.valid && text.ready;
  assign len_wide   = 32'(count_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_START, kind: KIND_DEC, digit_seen: 1'b0};
      count <= '0;
    end else if (accept) begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token.valid <= 1'b0;
    end else if (accept && emit) begin
      token.valid <= 1'b1;
    end else if (token.ready) begin
      token.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      token.kind         <= result.kind;
      token.status       <= result.status;
      token.length       <= len_wide[LEN_OUT_W-1:0];
      token.reread_count <= result.reread;
    end
  end

endmodule

@@ tb/sv/numeric_literal_scanner_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for numeric_literal_scanner: directed and random literal streams against a scan model.
module numeric_literal_scanner_tb;
  import nls_pkg::*;

  localparam int          IDLE_LIMIT   = 2000;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          LONG_DIGITS  = 40;
  localparam int          CODE_MAX     = 1114111;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef struct {
    char_t code;
    bit    eof;
    bit    hold;
  } text_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        status;
    logic [15:0] length;
    logic [1:0]  reread;
  } literal_t;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} ready_mode_t;

  logic clk;
  logic rst;

  nls_char_if text ();
  nls_lit_if  token ();

  numeric_literal_scanner u_top (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .token (token)
  );

  phase_t      sc_phase;
  kind_t       sc_kind;
  logic        sc_digit;
  logic [15:0] sc_count;

  text_item_t  char_q[$];
  literal_t    literal_q[$];
  int          err_count = 0;
  bit          stim_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // character classes
  function automatic bit dec_digit(char_t c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit letter(char_t c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit hex_digit(char_t c);
    return dec_digit(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  function automatic bit exp_letter(char_t c);
    return c == CH_LO_E || c == CH_UP_E;
  endfunction

  // scan model
  function automatic void clear_scan();
    sc_phase = PH_START;
    sc_kind  = KIND_DEC;
    sc_digit = 1'b0;
    sc_count = '0;
  endfunction

  function automatic void count_char();
    if (sc_count != COUNT_MAX) sc_count = sc_count + 16'd1;
  endfunction

  function automatic void emit_literal(logic status, logic [1:0] reread);
    literal_t lit;
    lit.kind   = sc_kind;
    lit.status = status;
    lit.length = sc_count;
    lit.reread = reread;
    literal_q.push_back(lit);
    clear_scan();
  endfunction

  function automatic void enter_prefix(kind_t k, phase_t p);
    count_char();
    sc_digit = 1'b0;
    sc_kind  = k;
    sc_phase = p;
  endfunction

  // c is the first character past the digits
  function automatic void end_of_digits(char_t c, bit eof);
    if (eof) emit_literal(sc_digit ? STATUS_OK : STATUS_BAD, REREAD_NONE);
    else if (!sc_digit) emit_literal(STATUS_BAD, REREAD_ONE);
    else if (letter(c)) begin
      if (c == CH_LO_F || c == CH_LO_D || c == CH_UP_L) begin
        count_char();
        emit_literal(STATUS_OK, REREAD_NONE);
      end else begin
        emit_literal(STATUS_BAD, REREAD_ONE);
      end
    end else begin
      emit_literal(STATUS_OK, REREAD_ONE);
    end
  endfunction

  function automatic void int_step(char_t c, bit eof);
    if (!eof && dec_digit(c)) begin
      count_char();
      sc_digit = 1'b1;
      sc_phase = PH_INT;
    end else if (!eof && c == CH_DOT) begin
      sc_phase = PH_DOT;
    end else if (!eof && exp_letter(c) && sc_digit) begin
      count_char();
      sc_phase = PH_EXP_SIGN;
    end else begin
      end_of_digits(c, eof);
    end
  endfunction

  function automatic void scan_char(char_t c, bit eof);
    case (sc_phase)
      PH_ZERO: begin
        if (!eof && (c == CH_LO_X || c == CH_UP_X)) enter_prefix(KIND_HEX, PH_HEX);
        else if (!eof && (c == CH_LO_B || c == CH_UP_B)) enter_prefix(KIND_BIN, PH_BIN);
        else if (!eof && (c == CH_LO_O || c == CH_UP_O)) enter_prefix(KIND_OCT, PH_OCT);
        else int_step(c, eof);
      end
      PH_INT: int_step(c, eof);
      PH_DOT: begin
        if (!eof && dec_digit(c)) begin
          count_char();
          count_char();
          sc_digit = 1'b1;
          sc_phase = PH_FRAC;
        end else begin
          emit_literal(sc_digit ? STATUS_OK : STATUS_BAD, eof ? REREAD_ONE : REREAD_TWO);
        end
      end
      PH_FRAC: begin
        if (!eof && dec_digit(c)) count_char();
        else if (!eof && exp_letter(c)) begin
          count_char();
          sc_phase = PH_EXP_SIGN;
        end else end_of_digits(c, eof);
      end
      PH_EXP_SIGN: begin
        if (!eof && (c == CH_PLUS || c == CH_MINUS)) begin
          count_char();
          sc_phase = PH_EXP_NEED;
        end else if (!eof && dec_digit(c)) begin
          count_char();
          sc_phase = PH_EXP_DIGITS;
        end else begin
          emit_literal(STATUS_BAD, eof ? REREAD_NONE : REREAD_ONE);
        end
      end
      PH_EXP_NEED: begin
        if (!eof && dec_digit(c)) begin
          count_char();
          sc_phase = PH_EXP_DIGITS;
        end else begin
          emit_literal(STATUS_BAD, eof ? REREAD_NONE : REREAD_ONE);
        end
      end
      PH_EXP_DIGITS: begin
        if (!eof && dec_digit(c)) count_char();
        else end_of_digits(c, eof);
      end
      PH_HEX: begin
        if (!eof && hex_digit(c)) begin
          count_char();
          sc_digit = 1'b1;
        end else end_of_digits(c, eof);
      end
      PH_BIN: begin
        if (!eof && (c == CH_0 || c == CH_1)) begin
          count_char();
          sc_digit = 1'b1;
        end else if (!eof && dec_digit(c)) emit_literal(STATUS_BAD, REREAD_ONE);
        else end_of_digits(c, eof);
      end
      PH_OCT: begin
        if (!eof && c >= CH_0 && c <= CH_7) begin
          count_char();
          sc_digit = 1'b1;
        end else if (!eof && dec_digit(c)) emit_literal(STATUS_BAD, REREAD_ONE);
        else end_of_digits(c, eof);
      end
      default: begin
        clear_scan();
        if (!eof && c == CH_0) begin
          count_char();
          sc_digit = 1'b1;
          sc_phase = PH_ZERO;
        end else begin
          int_step(c, eof);
        end
      end
    endcase
  endfunction

  // stimulus building
  function automatic char_t pick(string s);
    return char_t'(s[$urandom_range(0, s.len() - 1)]);
  endfunction

  task automatic push_char(char_t c);
    text_item_t it;
    it.code = c;
    it.eof  = 1'b0;
    it.hold = 1'b0;
    char_q.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(char_t'(s[i]));
  endtask

  task automatic push_digits(string s, int n);
    for (int i = 0; i < n; i++) push_char(pick(s));
  endtask

  task automatic push_end();
    text_item_t it;
    it.code = char_t'($urandom_range(0, CODE_MAX));
    it.eof  = 1'b1;
    it.hold = 1'b0;
    char_q.push_back(it);
  endtask

  // sender waits here until every pending literal has come out
  task automatic push_hold();
    text_item_t it;
    it.code = '0;
    it.eof  = 1'b0;
    it.hold = 1'b1;
    char_q.push_back(it);
  endtask

  task automatic gen_literal();
    int n;
    n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      0, 1: begin
        push_char(CH_0);
        push_char(pick("xX"));
        push_digits("0123456789abcdefABCDEF", n);
      end
      2: begin
        push_char(CH_0);
        push_char(pick("bB"));
        push_digits("01", n);
      end
      3: begin
        push_char(CH_0);
        push_char(pick("oO"));
        push_digits("01234567", n);
      end
      4: begin
        push_char(CH_DOT);
        push_digits("0123456789", n);
      end
      default: begin
        if ($urandom_range(0, 3) == 0) push_char(CH_0);
        push_digits("0123456789", n);
        if ($urandom_range(0, 2) == 0) begin
          push_char(CH_DOT);
          push_digits("0123456789", $urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) == 0) begin
          push_char(pick("eE"));
          if ($urandom_range(0, 2) != 0) push_char(pick("+-"));
          push_digits("0123456789", $urandom_range(0, 3));
        end
      end
    endcase
    if ($urandom_range(0, 7) == 0) push_digits("0123456789", 1);
    case ($urandom_range(0, 5))
      0: push_char(pick("fdL"));
      1: push_char(pick("abcgzAEQXZ_e"));
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: push_end();
      1: push_char(pick(" ;,)+-"));
      2: push_char(char_t'($urandom_range(128, CODE_MAX)));
      3: push_char(char_t'($urandom_range(0, CODE_MAX)));
      default: ;
    endcase
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: push_end();
        1: push_char(char_t'($urandom_range(0, CODE_MAX)));
        default: push_char(pick("0123456789xXbBoO.eE+-fdLaz_ "));
      endcase
    end
  endtask

  task automatic build_stimulus();
    int base;
    push_text("0X1F");
    push_end();
    push_text("0O78");
    push_text("1.5e-3f");
    push_text("9.a");
    push_text(".5");
    push_end();
    push_text("7q");
    push_text("e");
    push_text("0x");
    push_end();
    push_text("1E+");
    push_end();
    push_char(char_t'(CODE_MAX));
    push_text("0L");
    push_hold();
    base = char_q.size();
    while (char_q.size() - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_literal();
      if ($urandom_range(0, 19) == 0) begin
        push_end();
        push_hold();
      end
    end
    push_end();
    // one long literal
    push_char(CH_1);
    push_digits("7", LONG_DIGITS);
    push_char(CH_LO_F);
    push_text("12");
    push_end();
  endtask

  // driver
  int         burst_left = 1;
  int         gap_left   = 0;
  text_item_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      text.valid     <= 1'b0;
      text.char_code <= '0;
      text.at_end    <= 1'b0;
      burst_left     <= 1;
      gap_left       <= 0;
      clear_scan();
    end else begin
      if (text.valid && text.ready) scan_char(text.char_code, text.at_end);
      if (!text.valid || text.ready) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          text.valid <= 1'b0;
        end else if (char_q.size() == 0) begin
          text.valid <= 1'b0;
          stim_done  <= 1'b1;
        end else if (char_q[0].hold) begin
          text.valid <= 1'b0;
          if (literal_q.size() == 0) char_q.delete(0);
        end else begin
          drv_item       = char_q.pop_front();
          text.valid     <= 1'b1;
          text.char_code <= drv_item.code;
          text.at_end    <= drv_item.eof;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // result-side backpressure
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_tick = 0;

  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 150 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 2));
    case (ready_mode)
      RDY_ALWAYS: token.ready <= 1'b1;
      RDY_RANDOM: token.ready <= ($urandom_range(0, 3) != 0);
      default:    token.ready <= (ready_tick % 9) < 5;
    endcase
  end

  // monitor
  literal_t want;

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && token.valid && token.ready) begin
      if (literal_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transaction: expected none, got kind=%0d status=%0d len=%0d reread=%0d",
                 $time, token.kind, token.status, token.length, token.reread_count);
      end else begin
        want = literal_q.pop_front();
        check_field("kind", want.kind, token.kind);
        check_field("status", want.status, token.status);
        check_field("length", want.length, token.length);
        check_field("reread_count", want.reread, token.reread_count);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (token.valid && token.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (!stim_done || literal_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && literal_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
